// ===== hdl/hrld_pkg.sv =====
// hrld_pkg: shared constants for the http request line detector
// holds method word patterns, register indexes and reset values
// no dependencies
`default_nettype none

package hrld_pkg;

  // widths of the item fields and registers
  localparam int BYTE_W      = 8;
  localparam int PAYLOAD_W   = 11;
  localparam int MIN_LINE_W  = 8;
  localparam int LINE_CNT_W  = 9;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int WINDOW_W    = 56;
  localparam int RECENT_W    = 48;

  // default first line limit
  localparam int LINE_LIMIT_DEFAULT = 256;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PAYLOAD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LINE    = 2'd1;

  // register reset values
  localparam logic [PAYLOAD_W-1:0]  MIN_PAYLOAD_RESET = 11'd16;
  localparam logic [MIN_LINE_W-1:0] MIN_LINE_RESET    = 8'd12;

  // special byte codes
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_UA  = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UZ  = 8'h5a;

  // method words, right aligned, last letter in the low byte
  localparam int NUM_WORDS = 8;
  localparam logic [WINDOW_W-1:0] WORD_TEXT [NUM_WORDS] = '{
    WINDOW_W'("get"),
    WINDOW_W'("post"),
    WINDOW_W'("head"),
    WINDOW_W'("put"),
    WINDOW_W'("delete"),
    WINDOW_W'("options"),
    WINDOW_W'("trace"),
    WINDOW_W'("connect")
  };
  localparam int WORD_LEN [NUM_WORDS] = '{3, 4, 4, 3, 6, 7, 5, 7};

endpackage

`default_nettype wire

// ===== hdl/hrld_match.sv =====
// hrld_match: compares the seven byte window against the method words
// depends on hrld_pkg for the word patterns and lengths
`default_nettype none

module hrld_match
  import hrld_pkg::*;
(
  input  wire logic [WINDOW_W-1:0] window,
  output logic                     hit
);

  // one compare per word, only the word's own bytes take part
  always_comb begin
    logic [WINDOW_W-1:0] mask;
    hit = 1'b0;
    for (int k = 0; k < NUM_WORDS; k++) begin
      mask = ({WINDOW_W{1'b1}} >> (WINDOW_W - BYTE_W * WORD_LEN[k]));
      if ((window & mask) == WORD_TEXT[k]) begin
        hit = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/http_request_line_detector.sv =====
// http_request_line_detector: top level of the request line detector
// depends on hrld_pkg and hrld_match
//
// Usage: payload bytes enter on the input channel (data_byte, last_byte) under
// in_valid/in_stall, one transfer per byte. A byte with last_byte set ends the
// packet and produces one result transfer on the output channel (is_request)
// under out_valid/out_stall; other bytes produce nothing. The limits
// min_payload_bytes and min_line_bytes are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle, which it does not enforce.
// Timing: a byte taken sits in the input register and is evaluated there; when
// it moves on, a last byte loads the output register, which holds the result
// until it transfers.
// Throughput is one byte per cycle while no last byte waits on a stalled result;
// the per-byte state update (window compare and counters) is combinational.
// Reset clears all packet state, empties both registers and loads the limit
// defaults (16 and 12). While out_stall holds a result, non-last bytes keep
// flowing; a further last byte waits in the input register and in_stall rises.
`default_nettype none

module http_request_line_detector
  import hrld_pkg::*;
#(
  parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [BYTE_W-1:0]      data_byte,
  input  wire logic                   last_byte,
  // output channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        is_request
);

  localparam int POS_W = $clog2(LINE_LIMIT + 1);
  localparam logic [POS_W-1:0] POS_SEARCH_END = POS_W'(LINE_LIMIT - 1);
  localparam logic [POS_W-1:0] POS_LINE_END   = POS_W'(LINE_LIMIT);

  typedef enum logic [1:0] {
    PH_LINE,
    PH_CRLF,
    PH_DONE
  } phase_t;

  // configuration registers
  logic [PAYLOAD_W-1:0]  min_payload_bytes;
  logic [MIN_LINE_W-1:0] min_line_bytes;

  // input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_go;

  // packet state
  logic [RECENT_W-1:0]   recent_bytes, recent_bytes_next;
  logic [PAYLOAD_W-1:0]  payload_count, payload_count_next;
  logic [LINE_CNT_W-1:0] line_count, line_count_next;
  phase_t                line_phase, line_phase_next;
  logic                  word_hit, word_hit_next;
  logic                  nul_seen, nul_seen_next;
  logic [POS_W-1:0]      line_pos, line_pos_next;

  logic              crlf;
  logic [BYTE_W-1:0] folded;
  logic              match_hit;
  logic              result_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_payload_bytes <= MIN_PAYLOAD_RESET;
      min_line_bytes    <= MIN_LINE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_PAYLOAD: min_payload_bytes <= cfg_data;
        REG_MIN_LINE:    min_line_bytes    <= cfg_data[MIN_LINE_W-1:0];
        default:         ;
      endcase
    end
  end

  // a byte moves on unless it is last and the result slot is full and stalled
  assign s1_go    = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // fold upper case letters
  assign crlf   = (s1_byte == CHAR_CR) || (s1_byte == CHAR_LF);
  assign folded = (s1_byte >= CHAR_UA && s1_byte <= CHAR_UZ) ? (s1_byte | 8'h20) : s1_byte;

  hrld_match u_match (
    .window ({recent_bytes, folded}),
    .hit    (match_hit)
  );

  // per byte state update
  always_comb begin
    recent_bytes_next  = recent_bytes;
    word_hit_next      = word_hit;
    nul_seen_next      = nul_seen;
    line_pos_next      = line_pos;
    line_phase_next    = line_phase;
    line_count_next    = line_count;
    payload_count_next = payload_count;
    if (payload_count != {PAYLOAD_W{1'b1}}) begin
      payload_count_next = payload_count + 1'b1;
    end
    case (line_phase)
      PH_LINE: begin
        if (line_count != {LINE_CNT_W{1'b1}}) begin
          line_count_next = line_count + 1'b1;
        end
        if (crlf) begin
          line_phase_next = PH_CRLF;
        end else begin
          if (line_pos < POS_SEARCH_END && !nul_seen) begin
            if (s1_byte == CHAR_NUL) begin
              nul_seen_next = 1'b1;
            end else begin
              recent_bytes_next = {recent_bytes[RECENT_W-BYTE_W-1:0], folded};
              word_hit_next     = word_hit || match_hit;
            end
          end
          line_pos_next = line_pos + 1'b1;
          if (line_pos_next >= POS_LINE_END) begin
            line_phase_next = PH_CRLF;
          end
        end
      end
      PH_CRLF: begin
        if (crlf) begin
          if (line_count != {LINE_CNT_W{1'b1}}) begin
            line_count_next = line_count + 1'b1;
          end
        end else begin
          line_phase_next = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  assign result_next = (payload_count_next > min_payload_bytes) &&
                       (line_count_next > {1'b0, min_line_bytes}) && word_hit_next;

  // packet state registers, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || (s1_go && s1_last)) begin
      recent_bytes  <= '0;
      payload_count <= '0;
      line_count    <= '0;
      line_phase    <= PH_LINE;
      word_hit      <= 1'b0;
      nul_seen      <= 1'b0;
      line_pos      <= '0;
    end else if (s1_go) begin
      recent_bytes  <= recent_bytes_next;
      payload_count <= payload_count_next;
      line_count    <= line_count_next;
      line_phase    <= line_phase_next;
      word_hit      <= word_hit_next;
      nul_seen      <= nul_seen_next;
      line_pos      <= line_pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      is_request <= result_next;
    end
  end

`ifndef SYNTHESIS
  // a result only appears after a last byte was evaluated
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("result without a last byte");

  // no method word hit means no request
  assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last && !word_hit_next) |=> !is_request)
    else $error("request flagged without a word hit");

  // packet state is cleared after the last byte
  assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (payload_count == '0 && line_count == '0 && !word_hit))
    else $error("packet state not cleared");

  // line position never passes the line limit
  assert property (@(posedge clk) disable iff (rst)
    line_pos <= POS_LINE_END)
    else $error("line position beyond limit");
`endif

endmodule

`default_nettype wire

// ===== sim/hrld_checker.sv =====
// hrld_checker: scoreboard for the http request line detector
// tracks register writes and byte transfers, predicts is_request, compares results
// depends on hrld_pkg

module hrld_checker
  import hrld_pkg::*;
#(
  parameter int LINE_CAP = LINE_LIMIT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [BYTE_W-1:0]      data_byte,
  input  logic                   last_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   is_request,
  output int                     fail_count,
  output int                     results_owed
);

  typedef enum logic [1:0] {SCAN_LINE, SCAN_EOL, SCAN_DONE} scan_phase_t;

  // method words right aligned in a seven byte window
  localparam int N_METHODS = 8;
  localparam logic [55:0] METHOD_TEXT [N_METHODS] = '{
    "get", "post", "head", "put", "delete", "options", "trace", "connect"
  };
  localparam int METHOD_LEN [N_METHODS] = '{3, 4, 4, 3, 6, 7, 5, 7};

  // limits mirrored from register writes
  logic [PAYLOAD_W-1:0]  pay_floor;
  logic [MIN_LINE_W-1:0] line_floor;

  // per packet scan state
  logic [RECENT_W-1:0]   history;
  logic [PAYLOAD_W-1:0]  pay_bytes;
  logic [LINE_CNT_W-1:0] line_bytes;
  scan_phase_t           phase;
  logic                  method_seen;
  logic                  nul_hit;
  int                    line_pos;

  // expected verdicts in packet order
  logic verdict_q[$];

  function automatic logic method_at_tail(input logic [55:0] win);
    logic [55:0] mask;
    logic        found;
    found = 1'b0;
    for (int k = 0; k < N_METHODS; k++) begin
      mask = {56{1'b1}} >> (56 - 8 * METHOD_LEN[k]);
      if ((win & mask) == (METHOD_TEXT[k] & mask)) found = 1'b1;
    end
    return found;
  endfunction

  task automatic clear_scan();
    history     = '0;
    pay_bytes   = '0;
    line_bytes  = '0;
    phase       = SCAN_LINE;
    method_seen = 1'b0;
    nul_hit     = 1'b0;
    line_pos    = 0;
  endtask

  task automatic count_line_byte();
    if (line_bytes != '1) line_bytes++;
  endtask

  // advance the scan by one byte, queue a verdict on the packet end
  task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic fin);
    logic             eol;
    logic [BYTE_W-1:0] lc;
    eol = (b == CHAR_CR) || (b == CHAR_LF);
    if (pay_bytes != '1) pay_bytes++;
    case (phase)
      SCAN_LINE: begin
        if (eol) begin
          count_line_byte();
          phase = SCAN_EOL;
        end else begin
          // only the first LINE_CAP-1 bytes up to a NUL are searched
          if (line_pos < LINE_CAP - 1 && !nul_hit) begin
            if (b == CHAR_NUL) begin
              nul_hit = 1'b1;
            end else begin
              lc = (b >= CHAR_UA && b <= CHAR_UZ) ? b + 8'd32 : b;
              if (method_at_tail({history, lc})) method_seen = 1'b1;
              history = {history[RECENT_W-9:0], lc};
            end
          end
          count_line_byte();
          line_pos++;
          if (line_pos >= LINE_CAP) phase = SCAN_EOL;
        end
      end
      SCAN_EOL: begin
        if (eol) count_line_byte();
        else phase = SCAN_DONE;
      end
      default: ;
    endcase
    if (fin) begin
      verdict_q.push_back(pay_bytes > pay_floor && line_bytes > line_floor && method_seen);
      clear_scan();
    end
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      pay_floor  = MIN_PAYLOAD_RESET;
      line_floor = MIN_LINE_RESET;
      verdict_q.delete();
    end else begin
      // result transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("is_request transfer with nothing expected, actual %0b", is_request);
          fail_count++;
        end else begin
          if (is_request !== verdict_q[0]) begin
            $error("is_request mismatch: expected %0b actual %0b", verdict_q[0], is_request);
            fail_count++;
          end
          void'(verdict_q.pop_front());
        end
      end
      // byte transfer
      if (in_valid && !in_stall) scan_byte(data_byte, last_byte);
      // register write
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_PAYLOAD: pay_floor = cfg_data;
          REG_MIN_LINE:    line_floor = cfg_data[MIN_LINE_W-1:0];
          default: ;
        endcase
      end
    end
    results_owed = verdict_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: testbench top for the http request line detector
// drives request-like and noise packets with idle and stall patterns, gives the verdict
// depends on hrld_pkg, http_request_line_detector and hrld_checker

module tb_top;
  import hrld_pkg::*;

  localparam int LINE_CAP      = LINE_LIMIT_DEFAULT;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int MODE_BYTES    = 300;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [BYTE_W-1:0]      data_byte;
  logic                   last_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic                   is_request;

  int fail_count;
  int results_owed;
  int cycle_count;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_reqs;
  int hold_served;
  int hold_left;
  int mode_bytes;

  logic [BYTE_W-1:0] pkt[$];
  string method_names [8] = '{
    "get", "post", "head", "put", "delete", "options", "trace", "connect"
  };

  http_request_line_detector #(.LINE_LIMIT(LINE_CAP)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .is_request(is_request)
  );

  hrld_checker #(.LINE_CAP(LINE_CAP)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .is_request(is_request),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall, plus long hold-offs on request
  initial begin
    out_stall   = 1'b0;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_reqs != hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one transfer per byte, last_byte on the final one
  task automatic send_packet();
    int gap;
    for (int i = 0; i < pkt.size(); i++) begin
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 3) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      @(negedge clk);
      in_valid  <= 1'b1;
      data_byte <= pkt[i];
      last_byte <= (i == pkt.size() - 1);
      do @(posedge clk); while (in_stall);
      mode_bytes++;
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_text(input string s, input bit mix_case);
    logic [BYTE_W-1:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
      pkt.push_back(c);
    end
  endtask

  task automatic push_rand(input int n);
    repeat (n) pkt.push_back(BYTE_W'($urandom_range(255)));
  endtask

  task automatic push_printable(input int n);
    repeat (n) pkt.push_back(BYTE_W'($urandom_range(33, 126)));
  endtask

  // optional leading bytes or NUL, method, path, optional version, end of line run, header noise
  task automatic build_request();
    pkt.delete();
    if ($urandom_range(9) == 0) push_printable($urandom_range(1, 3));
    if ($urandom_range(9) == 0) pkt.push_back(CHAR_NUL);
    push_text(method_names[$urandom_range(7)], 1'b1);
    push_text(" /", 1'b0);
    push_printable($urandom_range(0, 12));
    if ($urandom_range(9) < 7) push_text(" HTTP/1.1", 1'b1);
    repeat ($urandom_range(0, 3)) pkt.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
    push_rand($urandom_range(0, 10));
  endtask

  // random bytes, sometimes with a whole or truncated method word inside
  task automatic build_noise();
    string w;
    pkt.delete();
    push_rand($urandom_range(1, 30));
    if ($urandom_range(1)) begin
      w = method_names[$urandom_range(7)];
      if ($urandom_range(1)) w = w.substr(0, w.len() - 2);
      push_text(w, 1'b1);
    end
    push_rand($urandom_range(0, 10));
  endtask

  // long first line with "get" ending at byte word_end
  task automatic build_long_line(input int word_end);
    pkt.delete();
    while (pkt.size() < word_end - 2) pkt.push_back("x");
    push_text("get", 1'b1);
    while (pkt.size() < LINE_CAP + 10) pkt.push_back("x");
    pkt.push_back(CHAR_CR);
    pkt.push_back(CHAR_LF);
    push_rand(3);
  endtask

  task automatic run_mode(input int tx, input int rx);
    int pick;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    mode_bytes  = 0;
    while (mode_bytes < MODE_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 3) build_long_line($urandom_range(240, 270));
      else if (pick < 75) build_request();
      else build_noise();
      send_packet();
    end
    go_quiet();
  endtask

  // stimulus
  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_MIN_PAYLOAD;
    cfg_data    = '0;
    in_valid    = 1'b0;
    data_byte   = '0;
    last_byte   = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed packets with both limits at zero
    write_reg(REG_MIN_PAYLOAD, 11'd0);
    write_reg(REG_MIN_LINE, 11'd0);
    pkt.delete();
    push_text("get", 1'b0);
    send_packet();
    pkt.delete();
    pkt.push_back(CHAR_NUL);
    send_packet();
    // line ends at once, method after the end of line run
    pkt.delete();
    pkt.push_back(CHAR_CR);
    pkt.push_back(CHAR_LF);
    push_text("PUT", 1'b0);
    send_packet();
    // NUL stops the search before the method
    pkt.delete();
    push_text("a", 1'b0);
    pkt.push_back(CHAR_NUL);
    push_text("post", 1'b0);
    pkt.push_back(CHAR_LF);
    send_packet();
    // a method split over two packets must not match
    pkt.delete();
    push_text("Ge", 1'b0);
    send_packet();
    pkt.delete();
    push_text("T", 1'b0);
    pkt.push_back(8'hff);
    send_packet();
    go_quiet();

    // random traffic, sender idles less than receiver
    write_reg(REG_MIN_PAYLOAD, MIN_PAYLOAD_RESET);
    write_reg(REG_MIN_LINE, CFG_DATA_W'(MIN_LINE_RESET));
    run_mode(27, 59);

    // random traffic, receiver idles less than sender
    write_reg(REG_MIN_PAYLOAD, CFG_DATA_W'($urandom_range(0, 40)));
    write_reg(REG_MIN_LINE, CFG_DATA_W'($urandom_range(0, 30)));
    run_mode(59, 27);

    // no idling, opened by a long receiver hold-off
    write_reg(REG_MIN_PAYLOAD, CFG_DATA_W'($urandom_range(0, 40)));
    write_reg(REG_MIN_LINE, CFG_DATA_W'($urandom_range(0, 30)));
    hold_reqs = hold_reqs + 1;
    run_mode(0, 0);

    // search cutoff at the line limit
    write_reg(REG_MIN_PAYLOAD, 11'd0);
    write_reg(REG_MIN_LINE, 11'd0);
    build_long_line(LINE_CAP - 2);
    send_packet();
    build_long_line(LINE_CAP - 1);
    send_packet();
    go_quiet();

    // high limits, upper data bits ignored for the line limit
    write_reg(REG_MIN_PAYLOAD, 11'd270);
    write_reg(REG_MIN_LINE, 11'h7ff);
    build_long_line(20);
    send_packet();
    go_quiet();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
